// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, and is disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a condition never holds while out of reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/mebe_pkg.sv =====
// Shared types, codes and constants for the MIDI event byte encoder.
package mebe_pkg;

  localparam logic [3:0] FuncNoteOff   = 4'd0;
  localparam logic [3:0] FuncNoteOn    = 4'd1;
  localparam logic [3:0] FuncPolyPress = 4'd2;
  localparam logic [3:0] FuncCtrl      = 4'd3;
  localparam logic [3:0] FuncProgram   = 4'd4;
  localparam logic [3:0] FuncChanPress = 4'd5;
  localparam logic [3:0] FuncPitch     = 4'd6;
  localparam logic [3:0] FuncMeta      = 4'd7;
  localparam logic [3:0] FuncMetaByte  = 4'd8;
  localparam logic [3:0] FuncTrack     = 4'd9;

  localparam logic [7:0] VlqCont    = 8'h80;
  localparam logic [7:0] VlqMask    = 8'h7F;
  localparam logic [7:0] MetaStatus = 8'hFF;

  // Byte slots of one event, sent in index order.
  localparam int SlotNum    = 7;
  localparam int SlotVlq3   = 0;
  localparam int SlotVlq2   = 1;
  localparam int SlotVlq1   = 2;
  localparam int SlotVlq0   = 3;
  localparam int SlotStatus = 4;
  localparam int SlotData1  = 5;
  localparam int SlotData2  = 6;

  localparam int FifoDepth = 2;
  localparam int FifoAw    = $clog2(FifoDepth);

  typedef struct packed {
    logic [SlotNum-1:0]      mask;
    logic [SlotNum-1:0][7:0] bytes;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/mebe_front.sv =====
// Front end: accepts events, tracks running status and builds byte descriptors.
module mebe_front import mebe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [3:0]  func_i,
  input  logic [27:0] time_delta_i,
  input  logic [3:0]  channel_i,
  input  logic [7:0]  data1_i,
  input  logic [7:0]  data2_i,
  output logic        push_o,
  output desc_t       desc_o,
  output logic [7:0]  rs_o
);

  logic [7:0] rs_q, rs_d;
  logic [7:0] status;

  always_comb begin
    desc_o = '0;
    rs_d   = rs_q;
    status = {1'b1, func_i[2:0], channel_i};

    desc_o.bytes[SlotVlq3]  = {1'b0, time_delta_i[27:21]} | VlqCont;
    desc_o.bytes[SlotVlq2]  = {1'b0, time_delta_i[20:14]} | VlqCont;
    desc_o.bytes[SlotVlq1]  = {1'b0, time_delta_i[13:7]} | VlqCont;
    desc_o.bytes[SlotVlq0]  = {1'b0, time_delta_i[6:0]} & VlqMask;
    desc_o.bytes[SlotData1] = data1_i;
    desc_o.bytes[SlotData2] = data2_i;
    desc_o.bytes[SlotStatus] = (func_i == FuncMeta) ? MetaStatus : status;

    if (func_i inside {[FuncNoteOff:FuncMeta]}) begin
      desc_o.mask[SlotVlq3] = |time_delta_i[27:21];
      desc_o.mask[SlotVlq2] = |time_delta_i[27:14];
      desc_o.mask[SlotVlq1] = |time_delta_i[27:7];
      desc_o.mask[SlotVlq0] = 1'b1;
      desc_o.mask[SlotData1] = 1'b1;
    end

    case (func_i)
      FuncMeta: begin
        desc_o.mask[SlotStatus] = 1'b1;
        desc_o.mask[SlotData2]  = 1'b1;
        rs_d = MetaStatus;
      end
      FuncNoteOff, FuncNoteOn, FuncPolyPress, FuncCtrl, FuncPitch,
      FuncProgram, FuncChanPress: begin
        desc_o.mask[SlotStatus] = (status != rs_q);
        desc_o.mask[SlotData2]  = !(func_i inside {FuncProgram, FuncChanPress});
        rs_d = status;
      end
      FuncMetaByte: desc_o.mask[SlotData1] = 1'b1;
      FuncTrack:    rs_d = '0;
      default:      rs_d = rs_q;
    endcase
  end

  assign push_o = accept_i && (desc_o.mask != '0);
  assign rs_o   = rs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= '0;
    end else if (accept_i) begin
      rs_q <= rs_d;
    end
  end

endmodule

// ===== rtl/mebe_fifo.sv =====
// Short descriptor queue between the front end and the byte sequencer.
module mebe_fifo import mebe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  desc_t      wdata_i,
  input  logic       pop_i,
  output desc_t      rdata_o,
  output fifo_stat_t stat_o
);

  desc_t             mem_q [FifoDepth];
  logic [FifoAw-1:0] wptr_q, rptr_q;
  logic [FifoAw:0]   cnt_q;

  assign stat_o.full  = (cnt_q == (FifoAw+1)'(FifoDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign rdata_o      = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == FifoAw'(FifoDepth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == FifoAw'(FifoDepth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mebe_back.sv =====
// Back end: walks the valid byte slots of a descriptor into the output register.
module mebe_back import mebe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  desc_t      desc_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       tvalid_o,
  input  logic       tready_i,
  output logic [7:0] tdata_o,
  output logic       tlast_o
);

  logic [SlotNum-1:0]      mask_q, mask_d, sel, rest;
  logic [SlotNum-1:0][7:0] bytes_q;
  logic                    valid_q, valid_d;
  logic [7:0]              byte_q, byte_d;
  logic                    last_q, last_d;
  logic                    load_ok;

  assign load_ok = !valid_q || tready_i;
  assign sel     = mask_q & (~mask_q + 1'b1);
  assign rest    = mask_q & ~sel;

  always_comb begin
    byte_d = '0;
    for (int i = 0; i < SlotNum; i++) begin
      byte_d = byte_d | (bytes_q[i] & {8{sel[i]}});
    end
  end

  always_comb begin
    valid_d = valid_q;
    last_d  = last_q;
    mask_d  = mask_q;
    pop_o   = 1'b0;
    if (load_ok) begin
      valid_d = (mask_q != '0);
      last_d  = (rest == '0);
      mask_d  = rest;
      pop_o   = (rest == '0) && !empty_i;
    end else if (mask_q == '0) begin
      pop_o   = !empty_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mask_q  <= '0;
    end else begin
      valid_q <= valid_d;
      mask_q  <= pop_o ? desc_i.mask : mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      bytes_q <= desc_i.bytes;
    end
    if (load_ok && (mask_q != '0)) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign tvalid_o = valid_q;
  assign tdata_o  = byte_q;
  assign tlast_o  = last_q;

endmodule

// ===== rtl/midi_event_byte_encoder_core.sv =====
// The first byte of an event goes from the descriptor queue to the sequencer's slot registers and
// then to the output register. Throughput: one byte per cycle while the master side is ready and
// descriptors are queued; an event has 1 to 7 bytes; a track start or an unused code sends none.
// Reset clears the running status, the descriptor queue and the output valid flag at once.
// There is no clearing pass; the block takes transactions in the first cycle after reset.
`include "assert_macros.svh"

module midi_event_byte_encoder_core import mebe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave side, one track event per transaction.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // time_delta[27:0], channel[31:28], data1[39:32], data2[47:40]
  input  logic [3:0]  s_axis_tuser,  // func[3:0]
  // Master side, one encoded byte per transaction.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
  output logic        m_axis_tlast   // last byte caused by one event
);

  logic       accept;
  logic       push;
  logic       pop;
  desc_t      wdesc;
  desc_t      rdesc;
  fifo_stat_t stat;
  logic [7:0] rs;

  // The front end only needs room in the queue; items that emit nothing are
  // still held back while it is full, which keeps the control simple.
  assign s_axis_tready = !stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // The front end classifies each event, updates the running status and
  // turns the event into up to seven byte slots with a mask of those sent.
  mebe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (s_axis_tuser),
    .time_delta_i (s_axis_tdata[27:0]),
    .channel_i    (s_axis_tdata[31:28]),
    .data1_i      (s_axis_tdata[39:32]),
    .data2_i      (s_axis_tdata[47:40]),
    .push_o       (push),
    .desc_o       (wdesc),
    .rs_o         (rs)
  );

  // Two descriptors of slack let the front end run on while the sequencer
  // is stalled by the downstream side.
  mebe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wdesc),
    .pop_i   (pop),
    .rdata_o (rdesc),
    .stat_o  (stat)
  );

  // The sequencer sends the lowest remaining slot each cycle unless the master side stalls, and
  // fetches the next descriptor while it sends the final byte, so events run back to back.
  mebe_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .desc_i   (rdesc),
    .empty_i  (stat.empty),
    .pop_o    (pop),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tlast_o  (m_axis_tlast)
  );

  `ASSERT_NEVER(a_no_pop_empty, pop && stat.empty, "descriptor popped from an empty queue")
  `ASSERT_CLK(a_track_clears_rs, accept && (s_axis_tuser == FuncTrack) |=> (rs == '0),
    "track start did not clear the running status")
  `ASSERT_CLK(a_meta_sets_rs, accept && (s_axis_tuser == FuncMeta) |=> (rs == MetaStatus),
    "meta event did not set the running status")

endmodule
